// ----- rtl/core/rlcd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the RGB LED chain driver.
package rlcd_pkg;

   localparam int BYTES_PER_PIXEL = 3;
   localparam int BITS_PER_BYTE   = 8;
   localparam int PIXEL_W         = BYTES_PER_PIXEL * BITS_PER_BYTE;
   localparam int REQ_DATA_W      = 32;
   localparam int RSP_DATA_W      = 8;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] LAST_COLOR = 2'd2;
   localparam logic [2:0] LAST_BIT   = 3'd7;

   localparam logic [7:0]  ONE_HIGH_RESET   = 8'd10;
   localparam logic [7:0]  ZERO_HIGH_RESET  = 8'd4;
   localparam logic [7:0]  BIT_PERIOD_RESET = 8'd18;
   localparam logic [15:0] LATCH_RESET      = 16'd4800;
   localparam logic [3:0]  ACTIVE_RESET     = 4'd8;

   typedef enum logic [1:0] {
      ACT_TICK      = 2'd0,
      ACT_SET_PIXEL = 2'd1,
      ACT_CLEAR     = 2'd2,
      ACT_SHOW      = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_SET     = 3'd1,
      CMD_SET_BAD = 3'd2,
      CMD_CLEAR   = 3'd3,
      CMD_SHOW    = 3'd4
   } cmd_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SEND  = 2'd1,
      PH_LATCH = 2'd2
   } phase_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ONE_HIGH   = 3'd0,
      CSR_ZERO_HIGH  = 3'd1,
      CSR_BIT_PERIOD = 3'd2,
      CSR_LATCH      = 3'd3,
      CSR_ACTIVE     = 3'd4
   } csr_index_type;

   // pixel_data is {blue, red, green}, green in the low byte (send order)
   typedef struct packed {
      cmd_kind_type       kind;
      logic [7:0]         pixel_index;
      logic [PIXEL_W-1:0] pixel_data;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  one_high;
      logic [7:0]  zero_high;
      logic [7:0]  bit_period;
      logic [15:0] latch;
      logic [3:0]  active;
   } cfg_type;

   // line_level in the low bit
   typedef struct packed {
      logic rejected;
      logic busy;
      logic line_level;
   } rsp_type;

endpackage

// ----- rtl/core/rlcd_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts requests and classifies them into queue commands.
module rlcd_front import rlcd_pkg::*; #(
   parameter int LED_COUNT = 8
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   logic [7:0] pixel_index;
   logic       in_range;

   assign req_tready  = !q_full;
   assign q_push      = req_tvalid && req_tready;
   assign pixel_index = req_tdata[7:0];
   assign in_range    = {1'b0, pixel_index} < 9'(LED_COUNT);

   always_comb begin
      q_cmd.pixel_index = pixel_index;
      // tdata is {blue, green, red, index}; store order is {blue, red, green}
      q_cmd.pixel_data  = {req_tdata[31:24], req_tdata[15:8], req_tdata[23:16]};
      unique case (action_type'(req_tuser))
         ACT_TICK:      q_cmd.kind = CMD_TICK;
         ACT_SET_PIXEL: q_cmd.kind = in_range ? CMD_SET : CMD_SET_BAD;
         ACT_CLEAR:     q_cmd.kind = CMD_CLEAR;
         ACT_SHOW:      q_cmd.kind = CMD_SHOW;
         default:       q_cmd.kind = CMD_TICK;
      endcase
   end

endmodule

// ----- rtl/core/rlcd_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the serializer back end.
module rlcd_queue import rlcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_cmd
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full    = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign valid   = count_ff != '0;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/core/rlcd_back.sv -----
`timescale 1ns / 1ps
// Back end: pixel store, bit serializer, latch gap and response register.
module rlcd_back import rlcd_pkg::*; #(
   parameter int LED_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  cmd_type               q_cmd,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PIX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int CNT_W = $clog2(LED_COUNT + 16);

   // pixel store: one row per LED, valid bits give the cleared value
   logic [PIXEL_W-1:0]   store_mem [LED_COUNT];
   logic [LED_COUNT-1:0] valid_ff, valid_in;
   logic [PIXEL_W-1:0]   rd_raw_ff;
   logic                 rd_ok_ff;

   phase_type         phase_ff, phase_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic [1:0]        color_ff, color_in;
   logic [2:0]        bit_ff, bit_in;
   logic [7:0]        tick_ff, tick_in;
   logic [15:0]       latch_ff, latch_in;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic [PIXEL_W-1:0] cur_pix;
   logic [7:0]         cur_byte;
   logic               cur_bit;
   logic [7:0]         high_ticks;
   logic [7:0]         tick_p1;
   logic [15:0]        latch_p1;
   logic [CNT_W-1:0]   pix_p1;
   logic [CNT_W-1:0]   frame_n;
   logic               last_byte;
   logic               busy_now;
   logic               do_set;
   logic               do_clear;
   logic [PIX_W-1:0]   set_addr;

   assign q_pop      = q_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 3)'(0), rsp_ff};
   assign set_addr   = q_cmd.pixel_index[PIX_W-1:0];

   // current pixel: read every cycle at the next pixel index
   assign cur_pix = rd_ok_ff ? rd_raw_ff : '0;

   always_comb begin
      unique case (color_ff)
         2'd0:    cur_byte = cur_pix[7:0];
         2'd1:    cur_byte = cur_pix[15:8];
         default: cur_byte = cur_pix[23:16];
      endcase
   end

   assign cur_bit    = cur_byte[LAST_BIT - bit_ff];
   assign high_ticks = cur_bit ? cfg.one_high : cfg.zero_high;
   assign tick_p1    = tick_ff + 8'd1;
   assign latch_p1   = latch_ff + 16'd1;
   assign pix_p1     = CNT_W'(pix_ff) + CNT_W'(1);

   // active pixel count clamped to 1..LED_COUNT
   always_comb begin
      if (cfg.active == 4'd0) begin
         frame_n = CNT_W'(1);
      end else if (CNT_W'(cfg.active) > CNT_W'(LED_COUNT)) begin
         frame_n = CNT_W'(LED_COUNT);
      end else begin
         frame_n = CNT_W'(cfg.active);
      end
   end

   assign last_byte = (pix_p1 > frame_n) || ((pix_p1 == frame_n) && (color_ff == LAST_COLOR));
   assign busy_now  = phase_ff != PH_IDLE;

   always_comb begin
      phase_in = phase_ff;
      pix_in   = pix_ff;
      color_in = color_ff;
      bit_in   = bit_ff;
      tick_in  = tick_ff;
      latch_in = latch_ff;
      valid_in = valid_ff;
      do_set   = 1'b0;
      do_clear = 1'b0;
      rsp_in   = '0;
      if (q_pop) begin
         unique case (q_cmd.kind)
            CMD_TICK: begin
               unique case (phase_ff)
                  PH_SEND: begin
                     rsp_in.line_level = tick_ff < high_ticks;
                     tick_in = tick_p1;
                     if (tick_p1 >= cfg.bit_period) begin
                        tick_in = '0;
                        bit_in  = bit_ff + 3'd1;
                        if (bit_ff == LAST_BIT) begin
                           if (last_byte) begin
                              pix_in   = '0;
                              color_in = '0;
                              latch_in = '0;
                              phase_in = (cfg.latch == '0) ? PH_IDLE : PH_LATCH;
                           end else if (color_ff == LAST_COLOR) begin
                              color_in = '0;
                              pix_in   = pix_p1[PIX_W-1:0];
                           end else begin
                              color_in = color_ff + 2'd1;
                           end
                        end
                     end
                  end
                  PH_LATCH: begin
                     latch_in = latch_p1;
                     if (latch_p1 >= cfg.latch) begin
                        latch_in = '0;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
            CMD_SET: begin
               if (busy_now) begin
                  rsp_in.rejected = 1'b1;
               end else begin
                  do_set             = 1'b1;
                  valid_in[set_addr] = 1'b1;
               end
            end
            CMD_SET_BAD: rsp_in.rejected = 1'b1;
            CMD_CLEAR, CMD_SHOW: begin
               if (busy_now) begin
                  rsp_in.rejected = 1'b1;
               end else begin
                  do_clear = q_cmd.kind == CMD_CLEAR;
                  if (do_clear) begin
                     valid_in = '0;
                  end
                  phase_in = PH_SEND;
                  pix_in   = '0;
                  color_in = '0;
                  bit_in   = '0;
                  tick_in  = '0;
                  latch_in = '0;
               end
            end
            default: ;
         endcase
         rsp_in.busy = phase_in != PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pix_ff       <= '0;
         color_ff     <= '0;
         bit_ff       <= '0;
         tick_ff      <= '0;
         latch_ff     <= '0;
         valid_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pix_ff   <= pix_in;
         color_ff <= color_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
         latch_ff <= latch_in;
         valid_ff <= valid_in;
         rd_ok_ff <= valid_ff[pix_in] && !do_clear;
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_set) begin
         store_mem[set_addr] <= q_cmd.pixel_data;
      end
      rd_raw_ff <= store_mem[pix_in];
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/core/rgb_led_chain_driver_core.sv -----
`timescale 1ns / 1ps
// RGB LED chain driver: top level with configuration registers.
// An accepted request passes through the command queue and then the response register.
// Throughput: one request per cycle unless responses stall; front, queue and back overlap.
// The pixel store is read every cycle at the next pixel index, so a frame runs at full rate.
// Reset (synchronous, active high) restores the register defaults, idles the serializer
// and clears the pixel valid bits at once, so the store reads as zero with no clearing pass.
module rgb_led_chain_driver_core import rlcd_pkg::*; #(
   parameter int LED_COUNT = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_tuser,   // action
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // pixel_index, red, green, blue
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // line_level, busy_res, rejected, zero pad
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff;
   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_valid;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   // configuration writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high   <= ONE_HIGH_RESET;
         cfg_ff.zero_high  <= ZERO_HIGH_RESET;
         cfg_ff.bit_period <= BIT_PERIOD_RESET;
         cfg_ff.latch      <= LATCH_RESET;
         cfg_ff.active     <= ACTIVE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ONE_HIGH:   cfg_ff.one_high   <= csr_data[7:0];
            CSR_ZERO_HIGH:  cfg_ff.zero_high  <= csr_data[7:0];
            CSR_BIT_PERIOD: cfg_ff.bit_period <= csr_data[7:0];
            CSR_LATCH:      cfg_ff.latch      <= csr_data;
            CSR_ACTIVE:     cfg_ff.active     <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // front: take the request, decode action and range-check the index
   rlcd_front #(
      .LED_COUNT (LED_COUNT)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   // queue lets the front keep taking requests while a response stalls, until it is full
   rlcd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (pop_cmd)
   );

   // back: busy check, store update, serializer step, response register
   rlcd_back #(
      .LED_COUNT (LED_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/core/rlcd_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the RGB LED chain driver, bound to the top level.
module rlcd_checker import rlcd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // reset empties the response register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // only ticks drive the line, and ticks are never rejected
   a_rej_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[0])
      else $error("rejected request shows a high line");

   // pad bits of the response stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:3] == '0)
      else $error("response pad bits set");

endmodule

bind rgb_led_chain_driver_core rlcd_checker u_rlcd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the RGB LED chain driver core.
module testbench;
   import rlcd_pkg::*;

   localparam int LEDS            = 8;
   localparam int STORE_LEN       = LEDS * BYTES_PER_PIXEL;
   localparam int RANDOM_REQUESTS = 250;
   localparam int CYCLE_LIMIT     = 2_000_000;
   // index with no register behind it; writes to it must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   // Tracks the serializer state and queues the line state each request should produce.
   class led_frame_scoreboard;
      logic [7:0]  one_high, zero_high, bit_period;
      logic [15:0] latch_len;
      logic [3:0]  active_cnt;
      logic [7:0]  store [STORE_LEN];
      int unsigned byte_pos, bit_pos;
      logic [7:0]  shift_reg, tick_cnt;
      logic [15:0] latch_cnt;
      phase_type   ph;
      rsp_type     line_due[$];
      int errors, requests, responses, frames, rejects, csr_writes;

      function new();
         one_high   = ONE_HIGH_RESET;
         zero_high  = ZERO_HIGH_RESET;
         bit_period = BIT_PERIOD_RESET;
         latch_len  = LATCH_RESET;
         active_cnt = ACTIVE_RESET;
         foreach (store[i]) store[i] = '0;
         byte_pos  = 0;
         bit_pos   = 0;
         shift_reg = '0;
         tick_cnt  = '0;
         latch_cnt = '0;
         ph        = PH_IDLE;
      endfunction

      // 0 behaves as one pixel, anything above the chain length as the whole chain
      function int unsigned frame_len_bytes();
         int unsigned n;
         n = active_cnt;
         if (n < 1) n = 1;
         if (n > LEDS) n = LEDS;
         return n * BYTES_PER_PIXEL;
      endfunction

      function bit frame_active();
         return ph != PH_IDLE;
      endfunction

      // one line clock: returns the level driven during it
      function logic advance_line();
         logic       level;
         logic [7:0] high;
         level = 1'b0;
         if (ph == PH_SEND) begin
            high  = shift_reg[7] ? one_high : zero_high;
            level = (tick_cnt < high);
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= bit_period) begin
               tick_cnt  = '0;
               shift_reg = shift_reg << 1;
               bit_pos++;
               if (bit_pos >= BITS_PER_BYTE) begin
                  bit_pos = 0;
                  byte_pos++;
                  if (byte_pos >= frame_len_bytes()) begin
                     byte_pos  = 0;
                     latch_cnt = '0;
                     ph = (latch_len == 0) ? PH_IDLE : PH_LATCH;
                  end else begin
                     shift_reg = store[byte_pos];
                  end
               end
            end
         end else if (ph == PH_LATCH) begin
            latch_cnt = latch_cnt + 16'd1;
            if (latch_cnt >= latch_len) begin
               latch_cnt = '0;
               ph = PH_IDLE;
            end
         end
         return level;
      endfunction

      function void note_request(action_type act, logic [7:0] idx, logic [7:0] red,
                                 logic [7:0] green, logic [7:0] blue);
         rsp_type due;
         bit      busy_now;
         due      = '0;
         busy_now = (ph != PH_IDLE);
         if (act == ACT_TICK) begin
            due.line_level = advance_line();
         end else if (busy_now) begin
            due.rejected = 1'b1;
         end else if (act == ACT_SET_PIXEL) begin
            if (idx >= LEDS) begin
               due.rejected = 1'b1;
            end else begin
               store[idx * BYTES_PER_PIXEL]     = green;
               store[idx * BYTES_PER_PIXEL + 1] = red;
               store[idx * BYTES_PER_PIXEL + 2] = blue;
            end
         end else begin
            if (act == ACT_CLEAR) foreach (store[i]) store[i] = '0;
            ph        = PH_SEND;
            byte_pos  = 0;
            bit_pos   = 0;
            tick_cnt  = '0;
            latch_cnt = '0;
            shift_reg = store[0];
            frames++;
         end
         due.busy = (ph != PH_IDLE);
         if (due.rejected) rejects++;
         requests++;
         line_due.push_back(due);
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] val);
         csr_writes++;
         case (idx)
            CSR_ONE_HIGH:   one_high   = val[7:0];
            CSR_ZERO_HIGH:  zero_high  = val[7:0];
            CSR_BIT_PERIOD: bit_period = val[7:0];
            CSR_LATCH:      latch_len  = val;
            CSR_ACTIVE:     active_cnt = val[3:0];
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic [RSP_DATA_W-1:0] data);
         rsp_type due;
         responses++;
         if (line_due.size() == 0) begin
            report($sformatf("response %0d (0x%02h) with nothing outstanding", responses, data));
            return;
         end
         due = line_due.pop_front();
         if (data[0] !== due.line_level)
            report($sformatf("response %0d line_level %b, want %b",
                             responses, data[0], due.line_level));
         if (data[1] !== due.busy)
            report($sformatf("response %0d busy %b, want %b", responses, data[1], due.busy));
         if (data[2] !== due.rejected)
            report($sformatf("response %0d rejected %b, want %b",
                             responses, data[2], due.rejected));
         if (data[RSP_DATA_W-1:3] !== '0)
            report($sformatf("response %0d pad bits %b not zero",
                             responses, data[RSP_DATA_W-1:3]));
      endtask
   endclass

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [1:0]             req_tuser   = '0;   // action
   logic [REQ_DATA_W-1:0]  req_tdata   = '0;   // pixel_index, red, green, blue
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;          // line_level, busy_res, rejected, zero pad
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   bit idling_on   = 1'b1;
   int stall_left  = 0;
   int cycle_count = 0;
   led_frame_scoreboard sb;

   rgb_led_chain_driver_core #(.LED_COUNT(LEDS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver back-pressure: random bursts of stalled cycles, started only while idling_on is set
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Leaves valid high after the handshake; quiesce() lowers it, as does a random idle gap in the next call.
   task push_request(action_type act, logic [7:0] idx, logic [7:0] red,
                     logic [7:0] green, logic [7:0] blue);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {blue, green, red, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, idx, red, green, blue);
   endtask

   task push_random(action_type act);
      push_request(act, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task run_to_idle();
      while (sb.frame_active()) push_random(ACT_TICK);
   endtask

   // stop sending, wait for every outstanding response, then let the pipe settle
   task quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.line_due.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // short bit periods and latch gaps keep frames short; upper data bits are junk on purpose
   task pick_timing();
      int v;
      if ($urandom_range(0, 1)) write_csr(CSR_ONE_HIGH, {8'($urandom), 8'($urandom_range(1, 6))});
      if ($urandom_range(0, 1)) write_csr(CSR_ZERO_HIGH, {8'($urandom), 8'($urandom_range(1, 6))});
      if ($urandom_range(0, 1)) begin
         v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
         write_csr(CSR_BIT_PERIOD, {8'($urandom), 8'(v)});
      end
      if ($urandom_range(0, 1)) write_csr(CSR_LATCH, 16'($urandom_range(0, 12)));
      if ($urandom_range(0, 1)) begin
         v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
         write_csr(CSR_ACTIVE, {12'($urandom), 4'(v)});
      end
   endtask

   // up to four pixel writes, an optional tick, a frame start, then ticks to idle with stray commands mixed in
   task run_session();
      logic [7:0] idx;
      repeat ($urandom_range(0, 4)) begin
         idx = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, LEDS - 1));
         push_request(ACT_SET_PIXEL, idx, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 3) == 0) push_random(ACT_TICK);
      push_random(($urandom_range(0, 3) == 0) ? ACT_CLEAR : ACT_SHOW);
      while (sb.frame_active()) begin
         if ($urandom_range(0, 19) == 0) push_random(action_type'($urandom_range(1, 3)));
         else push_random(ACT_TICK);
      end
      repeat ($urandom_range(0, 2)) push_random(ACT_TICK);
   endtask

   initial begin
      int random_base;
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle tick, pixel writes incl. out-of-range indexes
      push_random(ACT_TICK);
      push_request(ACT_SET_PIXEL, 8'd0, 8'h00, 8'hFF, 8'h81);
      push_request(ACT_SET_PIXEL, 8'd7, 8'hFF, 8'hFF, 8'hFF);
      push_request(ACT_SET_PIXEL, 8'd8, 8'h12, 8'h34, 8'h56);
      push_request(ACT_SET_PIXEL, 8'd255, 8'hAA, 8'h55, 8'hAA);
      // frame at reset bit timing over one pixel and a short latch gap,
      // with commands bounced while busy
      quiesce();
      write_csr(CSR_LATCH, 16'd8);
      write_csr(CSR_ACTIVE, 16'd1);
      push_random(ACT_SHOW);
      push_request(ACT_SET_PIXEL, 8'd1, 8'h01, 8'h02, 8'h03);
      push_random(ACT_CLEAR);
      push_random(ACT_SHOW);
      run_to_idle();

      quiesce();
      write_csr(CSR_ONE_HIGH, 16'd3);
      write_csr(CSR_ZERO_HIGH, 16'd1);
      write_csr(CSR_BIT_PERIOD, 16'd4);
      write_csr(CSR_LATCH, 16'd3);
      write_csr(CSR_ACTIVE, 16'd2);
      push_random(ACT_SHOW);
      repeat (10) push_random(ACT_TICK);
      // timing change in the middle of a frame applies immediately
      quiesce();
      write_csr(CSR_BIT_PERIOD, 16'd6);
      write_csr(CSR_ACTIVE, 16'd1);
      run_to_idle();

      // clear: all-zero frame over a chain clamped to full length, no latch gap
      quiesce();
      write_csr(CSR_ONE_HIGH, 16'd2);
      write_csr(CSR_BIT_PERIOD, 16'd1);
      write_csr(CSR_LATCH, 16'd0);
      write_csr(CSR_ACTIVE, 16'd15);
      push_random(ACT_CLEAR);
      run_to_idle();

      // degenerate periods, high time covering the period, zero pixels counted as one
      quiesce();
      write_csr(CSR_ONE_HIGH, 16'd255);
      write_csr(CSR_BIT_PERIOD, 16'd1);
      write_csr(CSR_LATCH, 16'd1);
      write_csr(CSR_ACTIVE, 16'd0);
      push_request(ACT_SET_PIXEL, 8'd0, 8'h5A, 8'hC3, 8'h0F);
      push_random(ACT_SHOW);
      run_to_idle();
      quiesce();
      write_csr(CSR_BIT_PERIOD, 16'd0);
      write_csr(CSR_SPARE, 16'hFFFF);
      push_random(ACT_SHOW);
      run_to_idle();
      quiesce();
      write_csr(CSR_BIT_PERIOD, 16'd3);
      write_csr(CSR_ZERO_HIGH, 16'd200);
      push_random(ACT_SHOW);
      run_to_idle();

      // random frames under varying timing and back-pressure
      random_base = sb.requests;
      while (sb.requests - random_base < RANDOM_REQUESTS) begin
         idling_on = ($urandom_range(0, 3) != 0);
         if (sb.requests == random_base || $urandom_range(0, 2) == 0) begin
            quiesce();
            pick_timing();
         end
         run_session();
      end

      // closing stretch at full rate: one pixel with a latch gap
      quiesce();
      idling_on = 1'b0;
      write_csr(CSR_ONE_HIGH, 16'd3);
      write_csr(CSR_ZERO_HIGH, 16'd1);
      write_csr(CSR_BIT_PERIOD, 16'd4);
      write_csr(CSR_LATCH, 16'd20);
      write_csr(CSR_ACTIVE, 16'd1);
      push_request(ACT_SET_PIXEL, 8'd0, 8'h96, 8'h69, 8'hF0);
      push_random(ACT_SHOW);
      run_to_idle();
      push_random(ACT_SET_PIXEL);

      quiesce();
      repeat (8) @(posedge clock);
      $display("Sent %0d requests, %0d frames started, %0d commands rejected, %0d register writes.",
               sb.requests, sb.frames, sb.rejects, sb.csr_writes);
      $display("Checked %0d responses with %0d mismatches.", sb.responses, sb.errors);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/rlcd_pkg.sv
rtl/core/rlcd_front.sv
rtl/core/rlcd_queue.sv
rtl/core/rlcd_back.sv
rtl/core/rgb_led_chain_driver_core.sv
rtl/core/rlcd_checker.sv
dv/testbench.sv
